### rtl/tdcpft_pkg.sv
`timescale 1ns / 1ps

package tdcpft_pkg;

    // Default sizes of the count fields and of the signed time values.
    localparam int COUNT_BITS_DEF = 24;
    localparam int VALUE_BITS_DEF = 48;

    // Fixed field widths.
    localparam int PERIOD_W    = 20;
    localparam int NOMINAL_W   = 40;
    localparam int ALPHA_W     = 17;
    localparam int WRAP_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 40;

    // Times are kept in 1/16 ps, and the averaging weight is Q16.
    localparam int FRAC_BITS  = 4;
    localparam int EMA_SHIFT  = 16;
    localparam int ROUND_HALF = 32768;

    // Width of the serial operand of the shared multiplier.
    localparam int MUL_B_W = 20;

    // Register reset values.
    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 20'd80000;
    localparam logic [NOMINAL_W-1:0] NOMINAL_RST = 40'd1000000000;
    localparam logic [ALPHA_W-1:0]   ALPHA_RST   = 17'd13107;
    localparam logic [ALPHA_W-1:0]   ALPHA_ONE   = 17'd65536;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_UPDATED = 2'd0,
        STATUS_TIMEOUT = 2'd1,
        STATUS_BAD_CAL = 2'd2
    } t_status;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CALIB_PERIOD = 2'd0,
        CFG_NOMINAL      = 2'd1,
        CFG_ALPHA        = 2'd2
    } t_cfg_index;

endpackage

### rtl/tdcpft_mul.sv
`timescale 1ns / 1ps

// Shift-and-add multiplier, one bit of the b operand per cycle, MSB first.
module tdcpft_mul import tdcpft_pkg::*; #(
    parameter int A_W = VALUE_BITS_DEF + 1,
    parameter int B_W = MUL_B_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [A_W-1:0]   r_a;
    logic [B_W-1:0]   r_b;
    logic [P_W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(B_W);
                r_a   <= i_a;
                r_b   <= i_b;
                r_acc <= '0;
            end else if (r_cnt != '0) begin
                r_acc  <= {r_acc[P_W-2:0], 1'b0} + (r_b[B_W-1] ? P_W'(r_a) : '0);
                r_b    <= {r_b[B_W-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### rtl/tdcpft_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The divisor must be nonzero.
module tdcpft_div import tdcpft_pkg::*; #(
    parameter int NUM_W = COUNT_BITS_DEF + PERIOD_W + FRAC_BITS + 1,
    parameter int DEN_W = COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    // The numerator shifts out of the top of r_q while quotient bits enter below.
    assign rem_sh = {r_rem, r_q[NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(NUM_W);
                r_q   <= i_num;
                r_den <= i_den;
                r_rem <= '0;
            end else if (r_cnt != '0) begin
                r_rem  <= ge ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
                r_q    <= {r_q[NUM_W-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### rtl/tdc_phase_frequency_tracker_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    meas_done, calib counts, stop count, irq flag
// output    out        o_valid / i_stall    status, phase, averages, freq_valid, wraps
// config    in         i_cfg_valid / ready  i_cfg_index, i_cfg_data
//
// An updated readout passes through the time-of-flight product, the division, the phase
// step, up to two average updates on the shared multiplier and the frequency step before
// its result reaches the done state. A timeout or bad calibration goes there from idle.
// Reset is synchronous and active low; it restores the register defaults and clears the tracker state and output valid.
// One readout is in work at a time. A new beat is taken while the last result waits on a
// stalled output; the finished result then waits in the done state.
module tdc_phase_frequency_tracker_unit import tdcpft_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_meas_done,
    input  logic [COUNT_BITS-1:0]        i_calib_count_one,
    input  logic [COUNT_BITS-1:0]        i_calib_count_two,
    input  logic [COUNT_BITS-1:0]        i_stop_time_count,
    input  logic                         i_irq_still_low,

    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [STATUS_W-1:0]          o_status,
    output logic signed [VALUE_BITS-1:0] o_phase_now,
    output logic signed [VALUE_BITS-1:0] o_phase_average,
    output logic signed [VALUE_BITS-1:0] o_freq_offset_now,
    output logic signed [VALUE_BITS-1:0] o_freq_offset_average,
    output logic                         o_freq_valid,
    output logic [WRAP_W-1:0]            o_wrap_total,

    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    // The multiplier's parallel operand carries either the stop count or the
    // magnitude of x - avg for an average update, which needs one bit more than a value.
    localparam int MUL_A_W = VALUE_BITS + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    // Numerator of the time of flight: stop * period * 16 + d/2.
    localparam int NUM_W   = COUNT_BITS + PERIOD_W + FRAC_BITS + 1;
    localparam int NOM_W   = NOMINAL_W + FRAC_BITS;
    localparam int WIDE_A  = (NUM_W > NOM_W) ? NUM_W : NOM_W;
    localparam int DIFF_W  = ((WIDE_A > VALUE_BITS) ? WIDE_A : VALUE_BITS) + 1;

    localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOF_MUL,
        S_DIV,
        S_PHASE,
        S_EMA_SETUP,
        S_EMA_MUL,
        S_EMA_APPLY,
        S_FREQ,
        S_DONE
    } t_state;

    t_state                  r_state;

    logic [PERIOD_W-1:0]     r_calib_period;
    logic [NOMINAL_W-1:0]    r_nominal;
    logic [ALPHA_W-1:0]      r_alpha;

    logic [COUNT_BITS-1:0]   r_den;
    logic                    r_irq;
    t_status                 r_status;
    logic                    r_fvalid;

    // Tracker state. seen bit 0: phase average seeded, bit 1: previous phase
    // valid, bit 2: frequency average seeded.
    logic [VALUE_BITS-1:0]   r_last_phase;
    logic [VALUE_BITS-1:0]   r_last_freq;
    logic [VALUE_BITS-1:0]   r_pavg;
    logic [VALUE_BITS-1:0]   r_favg;
    logic [VALUE_BITS-1:0]   r_prev;
    logic [2:0]              r_seen;
    logic [WRAP_W-1:0]       r_wrap;

    // Average update in flight: which average, its direction and its step.
    logic                    r_sel;
    logic                    r_up;
    logic [MUL_A_W-1:0]      r_m;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [VALUE_BITS-1:0]   r_out_phase;
    logic [VALUE_BITS-1:0]   r_out_pavg;
    logic [VALUE_BITS-1:0]   r_out_freq;
    logic [VALUE_BITS-1:0]   r_out_favg;
    logic                    r_out_fvalid;
    logic [WRAP_W-1:0]       r_out_wrap;

    logic                    mul_start;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic                    mul_done;
    logic [MUL_P_W-1:0]      mul_prod;

    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quot;

    logic                    cal_ok;
    logic                    out_load;
    logic [ALPHA_W-1:0]      alpha_eff;
    logic signed [DIFF_W-1:0] phase_diff;
    logic [DIFF_W-VALUE_BITS:0] phase_hi;
    logic [VALUE_BITS-1:0]   n_phase;
    logic signed [VALUE_BITS:0] freq_diff;
    logic [VALUE_BITS-1:0]   n_freq;
    logic [VALUE_BITS-1:0]   ema_x;
    logic [VALUE_BITS-1:0]   ema_avg;
    logic signed [VALUE_BITS:0] ema_d_up;
    logic signed [VALUE_BITS:0] ema_d_dn;
    logic                    ema_up;
    logic [MUL_A_W-1:0]      ema_mag;
    logic [MUL_P_W-1:0]      ema_round;
    logic [VALUE_BITS-1:0]   n_ema_avg;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign cal_ok    = (i_calib_count_two > i_calib_count_one);
    // A weight above one is taken as one, so the average follows its input.
    assign alpha_eff = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;

    // The finished result moves to the output register once that register is free
    // or is handing its beat over in this cycle.
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // The multiplier serves the time of flight when a good beat is taken and
    // every average update after that.
    always_comb begin
        mul_start = 1'b0;
        mul_a     = ema_mag;
        mul_b     = MUL_B_W'(alpha_eff);
        if (r_state == S_IDLE) begin
            mul_a     = MUL_A_W'(i_stop_time_count);
            mul_b     = MUL_B_W'(r_calib_period);
            mul_start = i_valid && i_meas_done && cal_ok;
        end else if (r_state == S_EMA_SETUP) begin
            mul_start = 1'b1;
        end
    end

    // Rounding to nearest: half the divisor is added before the division.
    assign div_start = (r_state == S_TOF_MUL) && mul_done;
    assign div_num   = NUM_W'({mul_prod[COUNT_BITS+PERIOD_W-1:0], {FRAC_BITS{1'b0}}})
                     + NUM_W'(r_den >> 1);

    // Phase is the time of flight less the nominal interval, saturated.
    assign phase_diff = $signed(DIFF_W'(div_quot))
                      - $signed(DIFF_W'({r_nominal, {FRAC_BITS{1'b0}}}));
    assign phase_hi   = phase_diff[DIFF_W-1:VALUE_BITS-1];
    assign n_phase    = ((&phase_hi) || !(|phase_hi)) ? phase_diff[VALUE_BITS-1:0]
                      : (phase_diff[DIFF_W-1] ? VMIN : VMAX);

    // Frequency offset is previous phase minus current phase, saturated.
    assign freq_diff = $signed({r_prev[VALUE_BITS-1], r_prev})
                     - $signed({r_last_phase[VALUE_BITS-1], r_last_phase});
    assign n_freq    = (freq_diff[VALUE_BITS] == freq_diff[VALUE_BITS-1])
                     ? freq_diff[VALUE_BITS-1:0]
                     : (freq_diff[VALUE_BITS] ? VMIN : VMAX);

    // Average step: the magnitude of x - avg goes through the multiplier with
    // the weight, is rounded half up at bit 16, and moves the average toward x.
    assign ema_x     = r_sel ? r_last_freq : r_last_phase;
    assign ema_avg   = r_sel ? r_favg : r_pavg;
    assign ema_d_up  = $signed({ema_x[VALUE_BITS-1], ema_x})
                     - $signed({ema_avg[VALUE_BITS-1], ema_avg});
    assign ema_d_dn  = $signed({ema_avg[VALUE_BITS-1], ema_avg})
                     - $signed({ema_x[VALUE_BITS-1], ema_x});
    assign ema_up    = !ema_d_up[VALUE_BITS];
    assign ema_mag   = ema_up ? ema_d_up : ema_d_dn;
    assign ema_round = mul_prod + MUL_P_W'(ROUND_HALF);
    // The step never exceeds the distance to x, so the sum stays in range.
    assign n_ema_avg = r_up ? (ema_avg + r_m[VALUE_BITS-1:0])
                            : (ema_avg - r_m[VALUE_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_calib_period <= PERIOD_RST;
            r_nominal      <= NOMINAL_RST;
            r_alpha        <= ALPHA_RST;
            r_last_phase   <= '0;
            r_last_freq    <= '0;
            r_pavg         <= '0;
            r_favg         <= '0;
            r_prev         <= '0;
            r_seen         <= '0;
            r_wrap         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CALIB_PERIOD: r_calib_period <= i_cfg_data[PERIOD_W-1:0];
                    CFG_NOMINAL:      r_nominal      <= i_cfg_data[NOMINAL_W-1:0];
                    CFG_ALPHA:        r_alpha        <= i_cfg_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_irq    <= i_irq_still_low;
                        r_den    <= i_calib_count_two - i_calib_count_one;
                        r_fvalid <= 1'b0;
                        if (!i_meas_done) begin
                            r_status <= STATUS_TIMEOUT;
                            r_state  <= S_DONE;
                        end else if (!cal_ok) begin
                            r_status <= STATUS_BAD_CAL;
                            r_state  <= S_DONE;
                        end else begin
                            r_status <= STATUS_UPDATED;
                            r_state  <= S_TOF_MUL;
                        end
                    end
                end
                S_TOF_MUL: begin
                    if (mul_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_last_phase <= n_phase;
                        r_state      <= S_PHASE;
                    end
                end
                S_PHASE: begin
                    if (r_seen[0]) begin
                        r_sel   <= 1'b0;
                        r_state <= S_EMA_SETUP;
                    end else begin
                        // The first phase seeds its average.
                        r_pavg    <= r_last_phase;
                        r_seen[0] <= 1'b1;
                        r_state   <= S_FREQ;
                    end
                end
                S_EMA_SETUP: begin
                    r_up    <= ema_up;
                    r_state <= S_EMA_MUL;
                end
                S_EMA_MUL: begin
                    if (mul_done) begin
                        r_m     <= ema_round[EMA_SHIFT +: MUL_A_W];
                        r_state <= S_EMA_APPLY;
                    end
                end
                S_EMA_APPLY: begin
                    if (r_sel) begin
                        r_favg  <= n_ema_avg;
                        r_state <= S_DONE;
                    end else begin
                        r_pavg  <= n_ema_avg;
                        r_state <= S_FREQ;
                    end
                end
                S_FREQ: begin
                    r_prev    <= r_last_phase;
                    r_seen[1] <= 1'b1;
                    if (r_irq) begin
                        r_wrap <= r_wrap + 1'b1;
                    end
                    if (r_seen[1]) begin
                        r_last_freq <= n_freq;
                        r_fvalid    <= 1'b1;
                        if (r_seen[2]) begin
                            r_sel   <= 1'b1;
                            r_state <= S_EMA_SETUP;
                        end else begin
                            // The first frequency offset seeds its average.
                            r_favg    <= n_freq;
                            r_seen[2] <= 1'b1;
                            r_state   <= S_DONE;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_status <= r_status;
                        r_out_phase  <= r_last_phase;
                        r_out_pavg   <= r_pavg;
                        r_out_freq   <= r_last_freq;
                        r_out_favg   <= r_favg;
                        r_out_fvalid <= r_fvalid;
                        r_out_wrap   <= r_wrap;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid               = r_out_valid;
    assign o_status              = r_out_status;
    assign o_phase_now           = r_out_phase;
    assign o_phase_average       = r_out_pavg;
    assign o_freq_offset_now     = r_out_freq;
    assign o_freq_offset_average = r_out_favg;
    assign o_freq_valid          = r_out_fvalid;
    assign o_wrap_total          = r_out_wrap;

    tdcpft_mul #(
        .A_W(MUL_A_W),
        .B_W(MUL_B_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    tdcpft_div #(
        .NUM_W(NUM_W),
        .DEN_W(COUNT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

endmodule

### rtl/tdcpft_checker.sv
`timescale 1ns / 1ps

module tdcpft_checker import tdcpft_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [STATUS_W-1:0]   o_status,
    input logic                  o_freq_valid,
    input logic [VALUE_BITS-1:0] o_phase_now,
    input logic [WRAP_W-1:0]     o_wrap_total
);

    // Reset leaves no result pending and the input open.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall left after reset");

    // One readout in work at a time: a taken beat closes the input.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input stayed open after a beat was taken");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_phase_now) && $stable(o_wrap_total))
        else $error("stalled result changed");

    a_freq_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_freq_valid |-> o_status == STATUS_UPDATED)
        else $error("frequency flagged on a result without update");

    // A new result only comes from a finished readout, which keeps the input closed.
    a_no_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_stall |=> !o_valid)
        else $error("result appeared with no readout in work");

endmodule

bind tdc_phase_frequency_tracker_unit tdcpft_checker #(
    .VALUE_BITS(VALUE_BITS)
) u_tdcpft_checker (.*);

### tb/tb_tdc_phase_frequency_tracker_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the TDC phase and frequency tracker. A class keeps its own copy of
// the tracker state and registers, predicts one result for every accepted readout beat and
// compares each accepted result beat against the oldest prediction.
module tb_tdc_phase_frequency_tracker_unit;
    import tdcpft_pkg::*;

    localparam int CB = COUNT_BITS_DEF;
    localparam int VB = VALUE_BITS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 166;
    localparam int SETTLE_CYCLES = 200;
    localparam int REPORT_LIMIT = 10;
    localparam int unsigned COUNT_MAX = (32'd1 << CB) - 1;
    localparam int unsigned ALPHA_FIELD_MAX = (32'd1 << ALPHA_W) - 1;
    localparam int unsigned PERIOD_HIGH = 1_000_000;
    localparam logic [NOMINAL_W-1:0] NOMINAL_MAX = '1;

    // The index that no register answers to; a write there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam longint VALUE_MAX = (longint'(1) <<< (VB - 1)) - 1;
    localparam longint VALUE_MIN = -VALUE_MAX - 1;

    typedef longint unsigned u64_t;

    typedef struct {
        logic          meas_done;
        logic [CB-1:0] calib_count_one;
        logic [CB-1:0] calib_count_two;
        logic [CB-1:0] stop_time_count;
        logic          irq_still_low;
    } readout_t;

    typedef struct {
        t_status              status;
        logic signed [VB-1:0] phase_now;
        logic signed [VB-1:0] phase_average;
        logic signed [VB-1:0] freq_offset_now;
        logic signed [VB-1:0] freq_offset_average;
        logic                 freq_valid;
        logic [WRAP_W-1:0]    wrap_total;
    } tracker_result_t;

    // Mirror of the tracker: registers, averages, seen flags and wrap count, together with
    // the results still owed by the block in the order they must come out.
    class tracker_expectations;
        u64_t              period_ps;
        u64_t              nominal_ps;
        u64_t              alpha_q;
        longint            phase_avg;
        longint            freq_avg;
        longint            prev_phase;
        longint            last_phase;
        longint            last_freq;
        bit                phase_seeded;
        bit                prev_known;
        bit                freq_seeded;
        logic [WRAP_W-1:0] wraps;
        tracker_result_t   pending_results[$];
        int                mismatches;

        function new();
            period_ps    = u64_t'(PERIOD_RST);
            nominal_ps   = u64_t'(NOMINAL_RST);
            alpha_q      = u64_t'(ALPHA_RST);
            phase_avg    = 0;
            freq_avg     = 0;
            prev_phase   = 0;
            last_phase   = 0;
            last_freq    = 0;
            phase_seeded = 1'b0;
            prev_known   = 1'b0;
            freq_seeded  = 1'b0;
            wraps        = '0;
            mismatches   = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CALIB_PERIOD: period_ps  = u64_t'(data[PERIOD_W-1:0]);
                CFG_NOMINAL:      nominal_ps = u64_t'(data[NOMINAL_W-1:0]);
                CFG_ALPHA:        alpha_q    = u64_t'(data[ALPHA_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint clamp_value(longint x);
            if (x > VALUE_MAX) return VALUE_MAX;
            if (x < VALUE_MIN) return VALUE_MIN;
            return x;
        endfunction

        // The average moves toward x by alpha times the distance, rounded on the magnitude.
        function longint ema_move(longint avg, longint x, u64_t weight);
            u64_t delta;
            u64_t step;
            if (x >= avg) delta = u64_t'(x - avg);
            else delta = u64_t'(avg - x);
            step = (delta >> EMA_SHIFT) * weight
                + (((delta & 64'hFFFF) * weight + u64_t'(ROUND_HALF)) >> EMA_SHIFT);
            if (x >= avg) return avg + longint'(step);
            return avg - longint'(step);
        endfunction

        function void note_readout(readout_t r);
            tracker_result_t want;
            u64_t            span;
            u64_t            tof;
            u64_t            weight;
            longint          phase;
            longint          freq;
            bit              fresh_freq;
            weight = (alpha_q > u64_t'(ALPHA_ONE)) ? u64_t'(ALPHA_ONE) : alpha_q;
            fresh_freq = 1'b0;
            if (!r.meas_done) begin
                want.status = STATUS_TIMEOUT;
            end else if (r.calib_count_two <= r.calib_count_one) begin
                want.status = STATUS_BAD_CAL;
            end else begin
                want.status = STATUS_UPDATED;
                span = u64_t'(r.calib_count_two) - u64_t'(r.calib_count_one);
                tof = (u64_t'(r.stop_time_count) * period_ps * 16 + span / 2) / span;
                phase = clamp_value(longint'(tof) - longint'(nominal_ps * 16));
                last_phase = phase;
                phase_avg = phase_seeded ? ema_move(phase_avg, phase, weight) : phase;
                phase_seeded = 1'b1;
                if (prev_known) begin
                    freq = clamp_value(prev_phase - phase);
                    last_freq = freq;
                    freq_avg = freq_seeded ? ema_move(freq_avg, freq, weight) : freq;
                    freq_seeded = 1'b1;
                    fresh_freq = 1'b1;
                end
                prev_phase = phase;
                prev_known = 1'b1;
                if (r.irq_still_low) wraps = wraps + 1'b1;
            end
            want.phase_now           = VB'(last_phase);
            want.phase_average       = VB'(phase_avg);
            want.freq_offset_now     = VB'(last_freq);
            want.freq_offset_average = VB'(freq_avg);
            want.freq_valid          = fresh_freq;
            want.wrap_total          = wraps;
            pending_results.push_back(want);
        endfunction

        function void flag(string field, longint want, longint got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_result(tracker_result_t got);
            tracker_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result beat with nothing expected: status %0d phase %0d",
                        got.status, got.phase_now);
                return;
            end
            want = pending_results.pop_front();
            if (got.status != want.status)
                flag("status", longint'(want.status), longint'(got.status));
            if (got.phase_now !== want.phase_now)
                flag("phase_now", longint'(want.phase_now), longint'(got.phase_now));
            if (got.phase_average !== want.phase_average)
                flag("phase_average", longint'(want.phase_average),
                    longint'(got.phase_average));
            if (got.freq_offset_now !== want.freq_offset_now)
                flag("freq_offset_now", longint'(want.freq_offset_now),
                    longint'(got.freq_offset_now));
            if (got.freq_offset_average !== want.freq_offset_average)
                flag("freq_offset_average", longint'(want.freq_offset_average),
                    longint'(got.freq_offset_average));
            if (got.freq_valid !== want.freq_valid)
                flag("freq_valid", longint'(want.freq_valid), longint'(got.freq_valid));
            if (got.wrap_total !== want.wrap_total)
                flag("wrap_total", longint'(want.wrap_total), longint'(got.wrap_total));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic                   i_meas_done = 1'b0;
    logic [CB-1:0]          i_calib_count_one = '0;
    logic [CB-1:0]          i_calib_count_two = '0;
    logic [CB-1:0]          i_stop_time_count = '0;
    logic                   i_irq_still_low = 1'b0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic signed [VB-1:0]   o_phase_now;
    logic signed [VB-1:0]   o_phase_average;
    logic signed [VB-1:0]   o_freq_offset_now;
    logic signed [VB-1:0]   o_freq_offset_average;
    logic                   o_freq_valid;
    logic [WRAP_W-1:0]      o_wrap_total;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    tracker_expectations expected = new();

    // When this is low, neither the readout sender nor the result sink inserts idle cycles.
    bit idle_on = 1'b1;
    int cycles = 0;

    tdc_phase_frequency_tracker_unit #(
        .COUNT_BITS(CB),
        .VALUE_BITS(VB)
    ) u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_meas_done          (i_meas_done),
        .i_calib_count_one    (i_calib_count_one),
        .i_calib_count_two    (i_calib_count_two),
        .i_stop_time_count    (i_stop_time_count),
        .i_irq_still_low      (i_irq_still_low),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_status             (o_status),
        .o_phase_now          (o_phase_now),
        .o_phase_average      (o_phase_average),
        .o_freq_offset_now    (o_freq_offset_now),
        .o_freq_offset_average(o_freq_offset_average),
        .o_freq_valid         (o_freq_valid),
        .o_wrap_total         (o_wrap_total),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog. A correct run needs a small fraction of this limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic readout_t make_readout(logic done, int unsigned one, int unsigned two,
            int unsigned stop, logic irq);
        readout_t r;
        r.meas_done       = done;
        r.calib_count_one = CB'(one);
        r.calib_count_two = CB'(two);
        r.stop_time_count = CB'(stop);
        r.irq_still_low   = irq;
        return r;
    endfunction

    // Most beats are good readouts. About half of those aim the stop count near the nominal
    // interval, so that the phase stays small and the averages track something sensible.
    // The rest are timeouts and bad calibrations with random content.
    function automatic readout_t random_readout();
        readout_t    r;
        int unsigned pick;
        int unsigned span;
        u64_t        target;
        pick = $urandom_range(0, 99);
        r.meas_done       = 1'b1;
        r.irq_still_low   = 1'($urandom_range(0, 1));
        r.calib_count_one = CB'($urandom);
        r.calib_count_two = CB'($urandom);
        r.stop_time_count = CB'($urandom);
        if (pick < 8) begin
            r.meas_done = 1'b0;
        end else if (pick < 15) begin
            if (r.calib_count_two > r.calib_count_one)
                {r.calib_count_one, r.calib_count_two} = {r.calib_count_two, r.calib_count_one};
            if (pick < 10) r.calib_count_two = r.calib_count_one;
        end else begin
            case ($urandom_range(0, 2))
                0:       span = $urandom_range(1, 64);
                1:       span = $urandom_range(1, 65536);
                default: span = $urandom_range(1, COUNT_MAX);
            endcase
            r.calib_count_one = CB'($urandom_range(0, COUNT_MAX - span));
            r.calib_count_two = r.calib_count_one + CB'(span);
            if (pick < 60 && expected.period_ps != 0) begin
                target = (expected.nominal_ps / expected.period_ps) * u64_t'(span)
                    + u64_t'($urandom_range(0, 511));
                if (target >= 256) target = target - 256;
                if (target <= u64_t'(COUNT_MAX)) r.stop_time_count = CB'(target);
            end
        end
        return r;
    endfunction

    task automatic drive_payload(input readout_t r);
        i_meas_done       <= r.meas_done;
        i_calib_count_one <= r.calib_count_one;
        i_calib_count_two <= r.calib_count_two;
        i_stop_time_count <= r.stop_time_count;
        i_irq_still_low   <= r.irq_still_low;
    endtask

    // Sends one readout beat. Called at a rising edge; returns at the edge that took the beat,
    // with valid still high so that a following beat can go out back to back. The handshake
    // is sampled at the falling edge, where nothing is in motion.
    task automatic send_readout(input readout_t r);
        int gap;
        bit taken;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            drive_payload(random_readout());
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        drive_payload(r);
        do begin
            @(negedge i_clk);
            taken = i_valid && !o_stall;
            @(posedge i_clk);
        end while (!taken);
        expected.note_readout(r);
    endtask

    // The sender stops and waits until every result it is owed has come back. With nothing
    // owed, valid is already low and is left alone.
    task automatic drain_results();
        if (expected.pending_results.size() != 0) begin
            i_valid <= 1'b0;
            while (expected.pending_results.size() != 0) @(posedge i_clk);
        end
    endtask

    // Writes all three registers back to back, and optionally the unused index too. Only
    // called while the tracker is idle.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] period_data,
            input logic [CFG_DATA_W-1:0] nominal_data,
            input logic [CFG_DATA_W-1:0] alpha_data, input bit with_unused);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [CFG_DATA_W-1:0]  data [4];
        bit                     taken;
        idx[0]  = CFG_CALIB_PERIOD;
        idx[1]  = CFG_NOMINAL;
        idx[2]  = CFG_ALPHA;
        idx[3]  = CFG_UNUSED;
        data[0] = period_data;
        data[1] = nominal_data;
        data[2] = alpha_data;
        data[3] = CFG_DATA_W'({$urandom, $urandom});
        for (int k = 0; k < (with_unused ? 4 : 3); k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= data[k];
            do begin
                @(negedge i_clk);
                taken = i_cfg_valid && o_cfg_ready;
                @(posedge i_clk);
            end while (!taken);
            expected.set_register(idx[k], data[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Result sink. Before each result beat it may hold stall, starting either right away, so the
    // stall falls while the tracker is still busy, or once the result shows up, so the
    // finished result has to wait.
    initial begin : result_sink
        int hold;
        bit taken;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = idle_on ? $urandom_range(0, 10) : 0;
            if (hold > 0) begin
                i_stall <= 1'b1;
                if ($urandom_range(0, 1) == 1) begin
                    do begin
                        @(negedge i_clk);
                    end while (!o_valid);
                    @(posedge i_clk);
                end
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                taken = o_valid && !i_stall;
                @(posedge i_clk);
            end while (!taken);
        end
    end

    // A result beat that is accepted at the coming rising edge is checked here, at the falling
    // edge before it, while every signal involved is steady.
    always @(negedge i_clk) begin : result_monitor
        tracker_result_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.status              = t_status'(o_status);
            got.phase_now           = o_phase_now;
            got.phase_average       = o_phase_average;
            got.freq_offset_now     = o_freq_offset_now;
            got.freq_offset_average = o_freq_offset_average;
            got.freq_valid          = o_freq_valid;
            got.wrap_total          = o_wrap_total;
            expected.check_result(got);
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] period_data;
        logic [CFG_DATA_W-1:0] nominal_data;
        logic [CFG_DATA_W-1:0] alpha_data;
        int                    errors;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: 80 ns calibration period, 1 ms nominal interval, weight 0.2.
        // A timeout and both kinds of bad calibration come before anything was measured,
        // so they must show the cleared registers. An interrupt flag on them counts nothing.
        send_readout(make_readout(1'b0, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b1));
        send_readout(make_readout(1'b1, 5000, 5000, 12345, 1'b1));
        send_readout(make_readout(1'b1, COUNT_MAX, 0, COUNT_MAX, 1'b1));
        // The first update seeds the phase average, and the frequency is not yet valid.
        // The stop count lands exactly on the nominal interval.
        send_readout(make_readout(1'b1, 0, 1000, 12_500_000, 1'b1));
        // The second update seeds the frequency average.
        send_readout(make_readout(1'b1, 0, 1000, 12_500_160, 1'b0));
        send_readout(make_readout(1'b1, 100, 1100, 12_499_840, 1'b1));
        // A timeout after updates holds every value and drops freq_valid.
        send_readout(make_readout(1'b0, 0, 0, 0, 1'b0));
        send_readout(make_readout(1'b1, COUNT_MAX - 1, COUNT_MAX, 0, 1'b0));
        send_readout(make_readout(1'b1, 0, COUNT_MAX, COUNT_MAX, 1'b1));
        send_readout(make_readout(1'b1, 3, 6, 7, 1'b0));
        drain_results();

        // Highest test period, no nominal offset, full weight so the averages follow the input.
        // The period write carries junk above its field. The phase saturates high, and the
        // frequency then swings to both rails.
        apply_settings({20'hFFFFF, 20'(PERIOD_HIGH)}, '0, CFG_DATA_W'(ALPHA_ONE), 1'b0);
        send_readout(make_readout(1'b1, COUNT_MAX - 1, COUNT_MAX, COUNT_MAX, 1'b1));
        send_readout(make_readout(1'b1, 0, COUNT_MAX, 0, 1'b0));
        send_readout(make_readout(1'b1, 0, 1, COUNT_MAX, 1'b1));
        drain_results();

        // Largest nominal interval and a weight above one, which acts as one. Going from the
        // most negative phase to a saturated one pushes the frequency past its low rail.
        apply_settings(CFG_DATA_W'(PERIOD_HIGH), CFG_DATA_W'(NOMINAL_MAX),
            {23'h7FFFFF, 17'h1FFFF}, 1'b0);
        send_readout(make_readout(1'b1, 0, 1, 0, 1'b0));
        send_readout(make_readout(1'b1, 0, 1, COUNT_MAX, 1'b1));
        drain_results();

        // Period of one picosecond and weight zero, so the averages stay put. The first
        // beat rounds an exact half upward. The unused index gets a write as well.
        apply_settings(CFG_DATA_W'(1), '0, '0, 1'b1);
        send_readout(make_readout(1'b1, 0, 32, 1, 1'b0));
        send_readout(make_readout(1'b1, 10, 42, 3, 1'b1));
        send_readout(make_readout(1'b1, 0, 3, 2, 1'b0));
        drain_results();

        // A zero period gives a zero time of flight; the smallest nonzero weight.
        apply_settings('0, CFG_DATA_W'(12345), CFG_DATA_W'(1), 1'b0);
        send_readout(make_readout(1'b1, 0, 7, COUNT_MAX, 1'b1));
        send_readout(make_readout(1'b1, 0, 7, 5, 1'b0));
        send_readout(make_readout(1'b0, COUNT_MAX, 0, 24'h5A5A5A, 1'b1));
        drain_results();

        // Random phases, each under its own settings. Every third phase runs without any
        // idle cycles on either side.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 3))
                0:       period_data = CFG_DATA_W'(PERIOD_RST);
                1:       period_data = CFG_DATA_W'(1);
                2:       period_data = CFG_DATA_W'(PERIOD_HIGH);
                default: period_data = CFG_DATA_W'($urandom_range(1, PERIOD_HIGH));
            endcase
            case ($urandom_range(0, 3))
                0:       nominal_data = CFG_DATA_W'(NOMINAL_RST);
                1:       nominal_data = '0;
                2:       nominal_data = CFG_DATA_W'(NOMINAL_MAX);
                default: nominal_data = CFG_DATA_W'({$urandom, $urandom});
            endcase
            case ($urandom_range(0, 3))
                0:       alpha_data = CFG_DATA_W'(ALPHA_RST);
                1:       alpha_data = CFG_DATA_W'($urandom_range(0, ALPHA_FIELD_MAX));
                2:       alpha_data = CFG_DATA_W'(ALPHA_ONE);
                default: alpha_data = CFG_DATA_W'($urandom_range(1, 4096));
            endcase
            if ($urandom_range(0, 1) == 1)
                period_data[CFG_DATA_W-1:PERIOD_W] = (CFG_DATA_W - PERIOD_W)'($urandom);
            if ($urandom_range(0, 1) == 1)
                alpha_data[CFG_DATA_W-1:ALPHA_W] = (CFG_DATA_W - ALPHA_W)'($urandom);
            apply_settings(period_data, nominal_data, alpha_data, $urandom_range(0, 3) == 0);
            idle_on = (p % 3 != 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 199) == 0) drain_results();
                send_readout(random_readout());
            end
            drain_results();
        end

        // Nothing is owed any more; give the block time to show any stray result.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        errors = expected.mismatches + expected.pending_results.size();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/tdcpft_pkg.sv
rtl/tdcpft_mul.sv
rtl/tdcpft_div.sv
rtl/tdc_phase_frequency_tracker_unit.sv
rtl/tdcpft_checker.sv
tb/tb_tdc_phase_frequency_tracker_unit.sv
